// ===== sv/sidta_pkg.sv =====
package sidta_pkg;

  // Input width and the BCD image that holds every 32-bit magnitude.
  localparam int unsigned BinW      = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned BitCntW   = $clog2(BinW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2D;

endpackage

// ===== sv/sidta_dabble.sv =====
module sidta_dabble
  import sidta_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [BinW-1:0] mag_i,
  output logic            done_o,
  output logic [BcdW-1:0] bcd_o
);

  logic [BinW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BcdW-1:0]    bcd_adj;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[BinW-1]};
      bin_d = {bin_q[BinW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BitCntW'(BinW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// Flow: bit-serial BCD conversion (one input bit per cycle), then dropping leading zeros,
// then one character per cycle, sign first if negative.
// A new number is accepted only once the sequencer is back in idle after its last character.
// Reset: asynchronous, active low; clears the sequencer and the strobe.
// The receiver cannot stall: each character shows for exactly one cycle.
module signed_int_to_decimal_ascii_core
  import sidta_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [BinW-1:0] value_i,
  output logic                   strobe_o,
  output logic [7:0]             char_code_o,
  output logic                   last_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  state_e              state_q;
  logic                neg_q;
  logic [BcdW-1:0]     dig_q;
  logic [DigCntW-1:0]  ndig_q;
  logic                strobe_q;
  logic [7:0]          char_q;
  logic                last_q;

  logic                accept;
  logic [BinW-1:0]     value_u;
  logic [BinW-1:0]     mag;
  logic                conv_done;
  logic [BcdW-1:0]     conv_bcd;
  logic [3:0]          top_digit;

  // A transaction enters only while the sequencer is idle.
  assign accept  = start && (state_q == StIdle);
  assign value_u = value_i;

  // Take the unsigned magnitude; the most negative value maps onto 2^31.
  assign mag = value_u[BinW-1] ? (BinW'(0) - value_u) : value_u;

  assign top_digit = dig_q[BcdW-1 -: 4];

  sidta_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .mag_i  (mag),
    .done_o (conv_done),
    .bcd_o  (conv_bcd)
  );

  // Sequencer: convert, drop leading zeros, emit the sign if negative, then emit digits from the top.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
      neg_q    <= 1'b0;
      ndig_q   <= '0;
      dig_q    <= '0;
      char_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            neg_q   <= value_u[BinW-1];
            state_q <= StConv;
          end
        end
        StConv: begin
          // Capture the finished BCD image with all digits still present.
          if (conv_done) begin
            dig_q   <= conv_bcd;
            ndig_q  <= DigCntW'(NumDigits);
            state_q <= StSkip;
          end
        end
        StSkip: begin
          // Drop zero digits at the top but always keep the last one.
          if (top_digit == 4'd0 && ndig_q != DigCntW'(1)) begin
            dig_q  <= {dig_q[BcdW-5:0], 4'b0000};
            ndig_q <= ndig_q - 1'b1;
          end else if (neg_q) begin
            state_q <= StSign;
          end else begin
            state_q <= StEmit;
          end
        end
        StSign: begin
          strobe_q <= 1'b1;
          char_q   <= AsciiMinus;
          last_q   <= 1'b0;
          state_q  <= StEmit;
        end
        StEmit: begin
          strobe_q <= 1'b1;
          char_q   <= AsciiZero + {4'b0000, top_digit};
          last_q   <= (ndig_q == DigCntW'(1));
          dig_q    <= {dig_q[BcdW-5:0], 4'b0000};
          ndig_q   <= ndig_q - 1'b1;
          if (ndig_q == DigCntW'(1)) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy        = (state_q != StIdle);
  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== dv/tb_signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_core;
  import sidta_pkg::*;

  // Random numbers after the directed table; the tail runs with no idling.
  localparam int RandomItems  = 410;
  localparam int NoIdleTail   = 60;
  localparam int DrainPauseAt = 150;
  // Stall limit: the slowest number through the block plus the longest idle gap, with margin.
  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 60;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_t;

  // One directed number. An empty text means the predictor supplies the characters.
  typedef struct {
    int    value;
    string text;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [BinW-1:0] value_i = '0;
  logic                   strobe_o;
  logic [7:0]             char_code_o;
  logic                   last_o;

  // Text typed in for the number on value_i; travels with it like any other input.
  string row_text = "";

  char_t pending_chars[$];
  char_t want;
  int    mismatches = 0;
  int    quiet_cycles = 0;

  dir_row_t directed_rows [20] = '{
    '{0,             "0"},
    '{1,             ""},
    '{-1,            "-1"},
    '{9,             ""},
    '{10,            ""},
    '{-10,           ""},
    '{99,            ""},
    '{100,           ""},
    '{-100,          ""},
    '{999999999,     ""},
    '{1000000000,    ""},
    '{-1000000000,   ""},
    '{1234567890,    ""},
    '{-1234567890,   ""},
    '{2147483647,    "2147483647"},
    '{-2147483647,   "-2147483647"},
    '{32'sh8000_0000, "-2147483648"},
    '{32'sh5555_5555, ""},
    '{32'shAAAA_AAAA, ""},
    '{2147483646,    ""}
  };

  signed_int_to_decimal_ascii_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict the characters of one number: sign, then digits most significant first.
  // The magnitude is a 32-bit unsigned value, so the most negative input needs no
  // path of its own.
  function automatic void render_decimal(input logic [31:0] raw);
    logic [31:0] mag;
    logic [3:0]  digs [10];
    int          n;
    n = 0;
    if (raw[31]) begin
      mag = 32'd0 - raw;
      pending_chars.push_back('{AsciiMinus, 1'b0});
    end else begin
      mag = raw;
    end
    do begin
      digs[n] = 4'(mag % 32'd10);
      mag     = mag / 32'd10;
      n++;
    end while (mag != 32'd0 && n < 10);
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{AsciiZero + 8'(digs[i]), i == 0});
    end
  endfunction

  // Queue a typed-in text; the last character carries the last flag.
  function automatic void queue_typed_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{8'(s[i]), i == s.len() - 1});
    end
  endfunction

  // Draw a number: often a random digit count so short and long texts both show up;
  // else a raw random word, powers of ten around their borders, small values or the extremes.
  function automatic int pick_value();
    int          v;
    int          ndig;
    longint      lo;
    longint      hi;
    int unsigned sel;
    v   = 0;
    sel = $urandom_range(0, 6);
    case (sel)
      0: begin
        v = int'($urandom());
      end
      1, 2, 3: begin
        ndig = $urandom_range(1, 10);
        lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
        hi   = 10 ** ndig - 1;
        if (hi > 2147483647) begin
          hi = 2147483647;
        end
        v = int'($urandom_range(int'(hi), int'(lo)));
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      4: begin
        ndig = $urandom_range(0, 9);
        v    = int'(10 ** ndig) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      5: begin
        v = $urandom_range(0, 40) - 20;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh8000_0001;
          3: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v;
  endfunction

  // Present one number and hold until the block takes it. Before raising start,
  // sometimes idle: either right away, so the gap lands inside the conversion, or
  // once the block has gone idle, so the gap lands between numbers.
  task automatic send_number(input int v, input string text, input bit idle_ok);
    if (idle_ok && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy !== 1'b0);
      end
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    row_text <= text;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Drop start and hold until every predicted character has come out.
  task automatic drain_all();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Record each accepted number, then check each character against the oldest
  // prediction. Pushes come before the check; a number's characters never show
  // on the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy === 1'b0) begin
        if (row_text.len() != 0) begin
          queue_typed_text(row_text);
        end else begin
          render_decimal(value_i);
        end
      end
      if (strobe_o === 1'b1) begin
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected character: code=%h last=%b",
                     $realtime, char_code_o, last_o);
          end
        end else begin
          want = pending_chars.pop_front();
          if (char_code_o !== want.code || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] character mismatch: expected code=%h last=%b, got code=%h last=%b",
                       $realtime, want.code, want.last, char_code_o, last_o);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when neither side has moved a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || strobe_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, digit-count borders, alternating bit patterns.
    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].value, directed_rows[i].text, 1'b1);
    end

    // Random numbers; once along the way, let the block run dry before going on.
    for (int n = 0; n < RandomItems; n++) begin
      if (n == DrainPauseAt) begin
        drain_all();
      end
      send_number(pick_value(), "", n < RandomItems - NoIdleTail);
    end

    // Wait out every predicted character, then SettleCycles more for strays.
    drain_all();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0d predicted characters never came out", pending_chars.size());
      end
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
